// ----- rtl/core/btb_pkg.sv -----
// ============================================================================
// btb_pkg: shared definitions for the breadcrumb trail buffer
// Field widths, register indexes, result codes, sequencer states and the
// control/flag bundles passed to the distance unit.
// ============================================================================
`default_nettype none

package btb_pkg;

  // Ring capacity ceiling and default trail depth
  localparam int MAX_CAP         = 16;
  localparam int TRAIL_DEPTH_DEF = 16;

  // Field widths
  localparam int POS_W    = 24;
  localparam int SPD_W    = 16;
  localparam int HD_W     = 16;
  localparam int KIND_W   = 2;
  localparam int ACT_W    = 2;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int CRUMB_W  = 2 * POS_W + HD_W;
  localparam int SQ_W     = 2 * POS_W;
  localparam int DIST_W   = 2 * POS_W + 1;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STRIDE_W    = 16;
  localparam int TSIZE_W     = 5;
  localparam int MINSPD_W    = 15;
  localparam int TOL_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TSIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINSPD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 2'd3;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd100;
  localparam logic [TSIZE_W-1:0]  TSIZE_RST  = 5'd10;
  localparam logic [MINSPD_W-1:0] MINSPD_RST = 15'd50;
  localparam logic [TOL_W-1:0]    TOL_RST    = 16'd50;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CRUMB  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // Sample actions
  localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DROPPED  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TRIMMED  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CONSUMED = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MX,
    ST_MY,
    ST_MT,
    ST_CMP,
    ST_DROP,
    ST_TRIM,
    ST_EMIT,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  // Distance unit operations
  typedef enum logic [2:0] {
    DU_NONE,
    DU_DIFF,
    DU_MX,
    DU_MY,
    DU_MT
  } du_op_t;

  typedef struct packed {
    du_op_t op;
  } dist_ctrl_t;

  typedef struct packed {
    logic ge;   // squared distance >= squared threshold
    logic le;   // squared distance <= squared threshold
  } dist_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/btb_ram.sv -----
// ============================================================================
// btb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module btb_ram #(
  parameter int WIDTH = btb_pkg::CRUMB_W,
  parameter int DEPTH = btb_pkg::MAX_CAP
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/btb_dist_unit.sv -----
// ============================================================================
// btb_dist_unit: shared squared-distance unit
// One 24x24 squarer reused for dx^2, dy^2 and threshold^2, with a product
// register and an accumulator; compares the sum against the threshold square.
// ============================================================================
`default_nettype none

module btb_dist_unit (
  input  wire logic                              clk,
  input  wire btb_pkg::dist_ctrl_t               ctrl,
  input  wire logic signed [btb_pkg::POS_W-1:0]  pa_x,
  input  wire logic signed [btb_pkg::POS_W-1:0]  pa_y,
  input  wire logic signed [btb_pkg::POS_W-1:0]  pb_x,
  input  wire logic signed [btb_pkg::POS_W-1:0]  pb_y,
  input  wire logic [btb_pkg::TOL_W-1:0]         thr,
  output      btb_pkg::dist_flags_t              flags
);

  logic signed [btb_pkg::POS_W:0]   dx, dy;
  logic [btb_pkg::POS_W-1:0]        dx_abs, dy_abs;
  logic [btb_pkg::POS_W-1:0]        adx, ady;
  logic [btb_pkg::POS_W-1:0]        mop;
  logic [btb_pkg::SQ_W-1:0]         sq;
  logic [btb_pkg::SQ_W-1:0]         prod;
  logic [btb_pkg::DIST_W-1:0]       acc;

  // Difference of two 24-bit values fits 25 bits; magnitude fits 24.
  assign dx = {pa_x[btb_pkg::POS_W-1], pa_x} - {pb_x[btb_pkg::POS_W-1], pb_x};
  assign dy = {pa_y[btb_pkg::POS_W-1], pa_y} - {pb_y[btb_pkg::POS_W-1], pb_y};
  assign dx_abs = dx[btb_pkg::POS_W] ? btb_pkg::POS_W'(-dx) : btb_pkg::POS_W'(dx);
  assign dy_abs = dy[btb_pkg::POS_W] ? btb_pkg::POS_W'(-dy) : btb_pkg::POS_W'(dy);

  always_comb begin
    unique case (ctrl.op)
      btb_pkg::DU_MX: mop = adx;
      btb_pkg::DU_MY: mop = ady;
      btb_pkg::DU_MT: mop = btb_pkg::POS_W'(thr);
      default:        mop = '0;
    endcase
  end

  assign sq = mop * mop;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      btb_pkg::DU_DIFF: begin
        adx <= dx_abs;
        ady <= dy_abs;
      end
      btb_pkg::DU_MX: begin
        prod <= sq;
      end
      btb_pkg::DU_MY: begin
        prod <= sq;
        acc  <= btb_pkg::DIST_W'(prod);
      end
      btb_pkg::DU_MT: begin
        prod <= sq;
        acc  <= acc + btb_pkg::DIST_W'(prod);
      end
      default: begin
      end
    endcase
  end

  assign flags.ge = (acc >= btb_pkg::DIST_W'(prod));
  assign flags.le = (acc <= btb_pkg::DIST_W'(prod));

endmodule

`default_nettype wire

// ----- rtl/core/breadcrumb_trail_buffer.sv -----
// ============================================================================
// breadcrumb_trail_buffer: bounded trail of planar poses
// Odometry samples drop, trim or consume crumbs; a read request walks the
// whole trail oldest first.
// ============================================================================
// Usage
//   Input channel (in_valid / in_stall): one beat is a request. req_type 0 is
//   an odometry sample, 1 reads out the trail. in_stall stays high from the
//   accepting edge until the sequencer is back in idle.
//   Output channel (out_valid / out_stall): a sample gives one status beat;
//   a readout gives one beat per crumb (oldest first) or one empty beat.
//   last marks the final beat of a request.
//   Config port: cfg_we writes cfg_data into register cfg_index at once.
//   Datapath: crumbs live in a RAM with registered read; distances go through
//   one shared squarer (dx^2, dy^2, threshold^2, then compare).
//     - sample, no distance needed: a first drop if due, then the status beat
//     - sample with a distance check: difference, squarings, compare, any drop/trim, status beat
//     - readout: per crumb a RAM read, then output load
//   The next request is taken in the cycle after the final beat is loaded
//   into the output register, even while that beat still waits.
//   Reset: trail empty, drop reference cleared, registers to defaults;
//   crumb storage itself is not cleared (only held crumbs are ever read).
//   Receiver stall: the output register holds its beat and the sequencer
//   waits in place, so nothing is lost or repeated.
// ============================================================================
`default_nettype none

module breadcrumb_trail_buffer #(
  parameter int TRAIL_DEPTH = btb_pkg::TRAIL_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [btb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [btb_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request channel
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                req_type,
  input  wire logic signed [btb_pkg::POS_W-1:0]    pos_x,
  input  wire logic signed [btb_pkg::POS_W-1:0]    pos_y,
  input  wire logic signed [btb_pkg::SPD_W-1:0]    vel_x,
  input  wire logic [btb_pkg::HD_W-1:0]            heading,
  // result channel
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [btb_pkg::KIND_W-1:0]          kind,
  output      logic [btb_pkg::ACT_W-1:0]           action,
  output      logic signed [btb_pkg::POS_W-1:0]    crumb_x,
  output      logic signed [btb_pkg::POS_W-1:0]    crumb_y,
  output      logic [btb_pkg::HD_W-1:0]            crumb_heading,
  output      logic [btb_pkg::IDX_W-1:0]           crumb_index,
  output      logic [btb_pkg::CNT_W-1:0]           crumb_count,
  output      logic                                last
);

  // Ring capacity, slot index width, count width
  localparam int Cap = (TRAIL_DEPTH < btb_pkg::MAX_CAP) ? TRAIL_DEPTH : btb_pkg::MAX_CAP;
  localparam int IW  = $clog2(Cap);
  localparam int CW  = $clog2(Cap + 1);
  localparam logic [IW:0]   CapS = (IW + 1)'(Cap);
  localparam logic [CW-1:0] CapC = CW'(Cap);

  // Slot arithmetic: sum of two values below 2*Cap folds back into range
  function automatic logic [IW-1:0] wrap_slot(input logic [IW:0] s);
    logic [IW:0] r;
    r = (s >= CapS) ? (s - CapS) : s;
    return r[IW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [btb_pkg::STRIDE_W-1:0] stride_mm;
  logic [btb_pkg::TSIZE_W-1:0]  trail_size;
  logic [btb_pkg::MINSPD_W-1:0] min_forward_speed;
  logic [btb_pkg::TOL_W-1:0]    consume_tolerance_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_mm            <= btb_pkg::STRIDE_RST;
      trail_size           <= btb_pkg::TSIZE_RST;
      min_forward_speed    <= btb_pkg::MINSPD_RST;
      consume_tolerance_mm <= btb_pkg::TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btb_pkg::CFG_STRIDE: stride_mm            <= cfg_data;
        btb_pkg::CFG_TSIZE:  trail_size           <= cfg_data[btb_pkg::TSIZE_W-1:0];
        btb_pkg::CFG_MINSPD: min_forward_speed    <= cfg_data[btb_pkg::MINSPD_W-1:0];
        btb_pkg::CFG_TOL:    consume_tolerance_mm <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective trail limit: 0 acts as 1, anything above capacity as capacity
  logic [CW-1:0] lim;
  always_comb begin
    if (trail_size == '0) begin
      lim = CW'(1);
    end else if (trail_size > btb_pkg::TSIZE_W'(Cap)) begin
      lim = CapC;
    end else begin
      lim = CW'(trail_size);
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  btb_pkg::state_t state, state_next;

  logic [IW-1:0]                  oldest, oldest_next;
  logic [CW-1:0]                  held, held_next;
  logic                           ref_valid, ref_valid_next;
  logic signed [btb_pkg::POS_W-1:0] ref_x, ref_y;
  logic [btb_pkg::ACT_W-1:0]      act, act_next;
  logic [IW-1:0]                  ri, ri_next;

  // latched request
  logic signed [btb_pkg::POS_W-1:0] px, py;
  logic [btb_pkg::HD_W-1:0]       hd;
  logic                           mode_drop;
  logic [btb_pkg::KIND_W-1:0]     emit_kind;

  logic in_acc;
  logic speed_ok;
  logic out_free;
  logic out_load;

  assign in_stall = (state != btb_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign speed_ok = $signed({vel_x[btb_pkg::SPD_W-1], vel_x})
                  > $signed({2'b00, min_forward_speed});

  // --------------------------------------------------------------------------
  // Crumb RAM and distance unit
  // --------------------------------------------------------------------------
  logic                         ram_we, ram_re;
  logic [IW-1:0]                ram_waddr, ram_raddr;
  logic [btb_pkg::CRUMB_W-1:0]  ram_wdata, ram_rdata;
  logic [IW:0]                  rd_off;

  logic signed [btb_pkg::POS_W-1:0] slot_x, slot_y;
  logic [btb_pkg::HD_W-1:0]         slot_hd;

  assign ram_wdata = {hd, py, px};
  assign slot_x    = ram_rdata[btb_pkg::POS_W-1:0];
  assign slot_y    = ram_rdata[2*btb_pkg::POS_W-1:btb_pkg::POS_W];
  assign slot_hd   = ram_rdata[btb_pkg::CRUMB_W-1:2*btb_pkg::POS_W];

  // write goes to slot_of(held); when full this is the oldest slot
  assign ram_waddr = wrap_slot((IW + 1)'(oldest) + (IW + 1)'(held));
  // idle reads the newest crumb for a possible consume, readout walks ri
  assign rd_off    = (state == btb_pkg::ST_IDLE) ? (IW + 1)'(held - CW'(1))
                                                 : (IW + 1)'(ri);
  assign ram_raddr = wrap_slot((IW + 1)'(oldest) + rd_off);

  btb_ram #(
    .WIDTH (btb_pkg::CRUMB_W),
    .DEPTH (Cap)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  btb_pkg::dist_ctrl_t  du_ctrl;
  btb_pkg::dist_flags_t du_flags;

  btb_dist_unit u_dist (
    .clk   (clk),
    .ctrl  (du_ctrl),
    .pa_x  (px),
    .pa_y  (py),
    .pb_x  (mode_drop ? ref_x : slot_x),
    .pb_y  (mode_drop ? ref_y : slot_y),
    .thr   (mode_drop ? stride_mm : consume_tolerance_mm),
    .flags (du_flags)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic [CW-1:0] trim_k;
  logic          rd_last;

  assign trim_k  = held - lim;
  assign rd_last = ((CW'(ri) + CW'(1)) == held);

  always_comb begin
    state_next     = state;
    oldest_next    = oldest;
    held_next      = held;
    ref_valid_next = ref_valid;
    act_next       = act;
    ri_next        = ri;
    du_ctrl.op     = btb_pkg::DU_NONE;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    out_load       = 1'b0;

    unique case (state)
      btb_pkg::ST_IDLE: begin
        ri_next  = '0;
        act_next = btb_pkg::ACT_NONE;
        if (in_acc) begin
          ram_re = (held != '0);
          if (req_type) begin
            state_next = (held == '0) ? btb_pkg::ST_EMIT : btb_pkg::ST_RD_ADDR;
          end else if (speed_ok) begin
            state_next = ref_valid ? btb_pkg::ST_DIFF : btb_pkg::ST_DROP;
          end else begin
            state_next = (held != '0) ? btb_pkg::ST_DIFF : btb_pkg::ST_EMIT;
          end
        end
      end
      btb_pkg::ST_DIFF: begin
        du_ctrl.op = btb_pkg::DU_DIFF;
        state_next = btb_pkg::ST_MX;
      end
      btb_pkg::ST_MX: begin
        du_ctrl.op = btb_pkg::DU_MX;
        state_next = btb_pkg::ST_MY;
      end
      btb_pkg::ST_MY: begin
        du_ctrl.op = btb_pkg::DU_MY;
        state_next = btb_pkg::ST_MT;
      end
      btb_pkg::ST_MT: begin
        du_ctrl.op = btb_pkg::DU_MT;
        state_next = btb_pkg::ST_CMP;
      end
      btb_pkg::ST_CMP: begin
        if (mode_drop) begin
          state_next = du_flags.ge ? btb_pkg::ST_DROP : btb_pkg::ST_EMIT;
        end else begin
          if (du_flags.le) begin
            held_next      = held - CW'(1);
            ref_valid_next = 1'b0;
            act_next       = btb_pkg::ACT_CONSUMED;
          end
          state_next = btb_pkg::ST_EMIT;
        end
      end
      btb_pkg::ST_DROP: begin
        ram_we = 1'b1;
        if (held >= CapC) begin
          oldest_next = wrap_slot((IW + 1)'(oldest) + (IW + 1)'(1));
          act_next    = btb_pkg::ACT_TRIMMED;
        end else begin
          held_next   = held + CW'(1);
          act_next    = btb_pkg::ACT_DROPPED;
        end
        ref_valid_next = 1'b1;
        // trimming to the limit only follows a drop against a held reference
        state_next = ref_valid ? btb_pkg::ST_TRIM : btb_pkg::ST_EMIT;
      end
      btb_pkg::ST_TRIM: begin
        if (held > lim) begin
          oldest_next = wrap_slot((IW + 1)'(oldest) + (IW + 1)'(trim_k));
          held_next   = lim;
          act_next    = btb_pkg::ACT_TRIMMED;
        end
        state_next = btb_pkg::ST_EMIT;
      end
      btb_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = btb_pkg::ST_IDLE;
        end
      end
      btb_pkg::ST_RD_ADDR: begin
        ram_re     = 1'b1;
        state_next = btb_pkg::ST_RD_DATA;
      end
      btb_pkg::ST_RD_DATA: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rd_last) begin
            state_next = btb_pkg::ST_IDLE;
          end else begin
            ri_next    = ri + IW'(1);
            state_next = btb_pkg::ST_RD_ADDR;
          end
        end
      end
      default: begin
        state_next = btb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btb_pkg::ST_IDLE;
      oldest    <= '0;
      held      <= '0;
      ref_valid <= 1'b0;
      ref_x     <= '0;
      ref_y     <= '0;
      act       <= btb_pkg::ACT_NONE;
      ri        <= '0;
    end else begin
      state     <= state_next;
      oldest    <= oldest_next;
      held      <= held_next;
      ref_valid <= ref_valid_next;
      act       <= act_next;
      ri        <= ri_next;
      if (state == btb_pkg::ST_DROP) begin
        ref_x <= px;
        ref_y <= py;
      end
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px        <= pos_x;
      py        <= pos_y;
      hd        <= heading;
      mode_drop <= speed_ok;
      emit_kind <= req_type ? btb_pkg::KIND_EMPTY : btb_pkg::KIND_STATUS;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic is_crumb;
  assign is_crumb = (state == btb_pkg::ST_RD_DATA);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      crumb_count <= btb_pkg::CNT_W'(held_next);
      if (is_crumb) begin
        kind          <= btb_pkg::KIND_CRUMB;
        action        <= btb_pkg::ACT_NONE;
        crumb_x       <= slot_x;
        crumb_y       <= slot_y;
        crumb_heading <= slot_hd;
        crumb_index   <= btb_pkg::IDX_W'(ri);
        last          <= rd_last;
      end else begin
        kind          <= emit_kind;
        action        <= act;
        crumb_x       <= '0;
        crumb_y       <= '0;
        crumb_heading <= '0;
        crumb_index   <= '0;
        last          <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CapC)
    else $error("trail count above ring capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("request taken while previous one still in flight");

  a_crumb_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == btb_pkg::KIND_CRUMB))
      |-> (({1'b0, crumb_index} < crumb_count) && (action == btb_pkg::ACT_NONE)))
    else $error("readout beat index beyond held count");

endmodule

`default_nettype wire
